// ===== sv/pool22_pkg.sv =====
`timescale 1ns / 1ps

package pool22_pkg;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;
    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 13;
    localparam int ROW_BITS      = 12;
    localparam int HEIGHT_LIMIT  = 4096;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_WIDTH  = 2'd0;
    localparam reg_idx_t REG_HEIGHT = 2'd1;
    localparam reg_idx_t REG_MODE   = 2'd2;

    // what the row of an item means for the window
    typedef enum logic [1:0] {
        KIND_STORE,
        KIND_PAD,
        KIND_FULL
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        logic      col_odd;
        logic      col_last;
        logic      frame_end;
    } item_tag_t;

endpackage

// ===== sv/pool22_ram.sv =====
`timescale 1ns / 1ps

module pool22_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/pool22_seq.sv =====
`timescale 1ns / 1ps

module pool22_seq #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pool22_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [pool22_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [pool22_pkg::CFG_DATA_BITS-1:0] prdata,
    input  logic                                s_valid,
    input  logic                                stage_ready,
    output logic                                accept,
    output pool22_pkg::item_tag_t               tag,
    output logic                                ram_we,
    output logic                                ram_re,
    output logic [$clog2(MAX_WIDTH)-1:0]        ram_addr,
    output logic                                avg_mode
);

    localparam int WB = $clog2(MAX_WIDTH);
    localparam int HB = pool22_pkg::HEIGHT_BITS;

    logic [pool22_pkg::WIDTH_BITS-1:0] width_reg;
    logic [HB-1:0]                     height_reg;
    logic                              mode_reg;
    logic [WB-1:0]                     col_reg, col_next;
    logic [pool22_pkg::ROW_BITS-1:0]   row_reg, row_next;
    logic [WB:0]                       w_eff;
    logic [HB-1:0]                     h_eff;
    logic                              cfg_wr;
    logic                              col_last, row_last, pad_row;
    pool22_pkg::reg_idx_t              idx;

    assign idx    = paddr[3:2];
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= pool22_pkg::WIDTH_BITS'(2);
            height_reg <= HB'(2);
            mode_reg   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (idx)
                pool22_pkg::REG_WIDTH:  width_reg  <= pwdata[pool22_pkg::WIDTH_BITS-1:0];
                pool22_pkg::REG_HEIGHT: height_reg <= pwdata[HB-1:0];
                pool22_pkg::REG_MODE:   mode_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            pool22_pkg::REG_WIDTH:  prdata = pool22_pkg::CFG_DATA_BITS'(width_reg);
            pool22_pkg::REG_HEIGHT: prdata = pool22_pkg::CFG_DATA_BITS'(height_reg);
            pool22_pkg::REG_MODE:   prdata = pool22_pkg::CFG_DATA_BITS'(mode_reg);
            default:                prdata = '0;
        endcase
    end

    // out of range sizes are clamped
    always_comb begin
        if (width_reg == '0) begin
            w_eff = (WB + 1)'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = (WB + 1)'(MAX_WIDTH);
        end else begin
            w_eff = (WB + 1)'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = HB'(1);
        end else if (32'(height_reg) > pool22_pkg::HEIGHT_LIMIT) begin
            h_eff = HB'(pool22_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = height_reg;
        end
    end

    assign col_last = ({1'b0, col_reg} == w_eff - (WB + 1)'(1));
    assign row_last = ({1'b0, row_reg} == h_eff - HB'(1));
    // an odd height leaves a last even row with no partner row below
    assign pad_row  = !row_reg[0] && h_eff[0] && row_last;

    assign accept = s_valid && stage_ready;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb begin
        if (row_reg[0]) begin
            tag.kind = pool22_pkg::KIND_FULL;
        end else if (pad_row) begin
            tag.kind = pool22_pkg::KIND_PAD;
        end else begin
            tag.kind = pool22_pkg::KIND_STORE;
        end
        tag.col_odd   = col_reg[0];
        tag.col_last  = col_last;
        tag.frame_end = col_last && row_last;
    end

    // the upper row entry is written a whole row before it is read back,
    // so a read in the lower row never meets a write to the same entry in flight
    assign ram_we   = accept && (tag.kind == pool22_pkg::KIND_STORE);
    assign ram_re   = accept;
    assign ram_addr = col_reg;
    assign avg_mode = mode_reg;

endmodule

// ===== sv/pool22_calc.sv =====
`timescale 1ns / 1ps

module pool22_calc #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  pool22_pkg::item_tag_t  tag,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] upper,
    input  logic                   avg_mode,
    output logic                   stage_ready,
    output logic                   out_valid,
    output logic [SAMPLE_BITS-1:0] out_value,
    output logic                   out_last,
    input  logic                   out_ready
);

    localparam int SB = SAMPLE_BITS;

    logic                  s1_valid_reg;
    pool22_pkg::item_tag_t tag_reg;
    logic signed [SB-1:0]  x_reg;
    logic signed [SB-1:0]  left_reg, left_next;
    logic signed [SB-1:0]  uleft_reg, uleft_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SB-1:0]         out_value_reg;
    logic                  out_last_reg;
    logic signed [SB-1:0]  top;
    logic signed [SB+1:0]  sum4, sum_pad;
    logic signed [SB:0]    sum2;
    logic signed [SB-1:0]  max_a, max_b, max_pair;
    logic signed [SB-1:0]  val;
    logic                  emit, out_free, fire;

    assign top      = upper;
    assign out_free = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && out_free;
    assign stage_ready = !s1_valid_reg || out_free;

    assign sum4    = (SB + 2)'(uleft_reg) + (SB + 2)'(top) + (SB + 2)'(left_reg)
                   + (SB + 2)'(x_reg);
    assign sum_pad = (SB + 2)'(left_reg) + (SB + 2)'(x_reg);
    assign sum2    = (SB + 1)'(top) + (SB + 1)'(x_reg);
    assign max_a   = (uleft_reg > top) ? uleft_reg : top;
    assign max_b   = (left_reg > x_reg) ? left_reg : x_reg;
    assign max_pair = (top > x_reg) ? top : x_reg;

    always_comb begin
        emit       = 1'b0;
        val        = x_reg;
        left_next  = left_reg;
        uleft_next = uleft_reg;
        unique case (tag_reg.kind)
            pool22_pkg::KIND_FULL: begin
                if (tag_reg.col_odd) begin
                    emit = 1'b1;
                    val  = avg_mode ? SB'(sum4 >>> 2) : ((max_a > max_b) ? max_a : max_b);
                end else if (tag_reg.col_last) begin
                    emit = 1'b1;
                    val  = avg_mode ? SB'(sum2 >>> 1) : max_pair;
                end else begin
                    left_next  = x_reg;
                    uleft_next = top;
                end
            end
            pool22_pkg::KIND_PAD: begin
                // missing lower row: zero for average, ignored for max
                if (tag_reg.col_odd) begin
                    emit = 1'b1;
                    val  = avg_mode ? SB'(sum_pad >>> 2) : max_b;
                end else if (tag_reg.col_last) begin
                    emit = 1'b1;
                    val  = avg_mode ? (x_reg >>> 1) : x_reg;
                end else begin
                    left_next = x_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || (fire && emit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            uleft_reg     <= '0;
        end else begin
            if (stage_ready) begin
                s1_valid_reg <= accept;
            end
            out_valid_reg <= out_valid_next;
            if (fire) begin
                left_reg  <= left_next;
                uleft_reg <= uleft_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tag_reg <= tag;
            x_reg   <= sample;
        end
        if (fire && emit) begin
            out_value_reg <= val;
            out_last_reg  <= tag_reg.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== sv/pool_2x2_stride2_stream.sv =====
`timescale 1ns / 1ps
// channel   | ports          | carries
// ----------+----------------+---------------------------------------------
// input     | s_tvalid/tready| s_tdata: sample
// result    | m_tvalid/tready| m_tdata: pooled_value, m_tlast: frame_last
// config    | apb, psel..    | 0x0 image_width, 0x4 image_height, 0x8 mode
//
// one sample per clock while results are taken; a result leaves after the sample that
// closes its window passes the line store read, then the window logic into the output register.
// synchronous active-low reset clears counters and valids; line store is not cleared.
// a stalled result holds the window stage, which then holds the input.
// any config write restarts the plane at row 0, column 0.

module pool_2x2_stride2_stream #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pool22_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [pool22_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [pool22_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                 pready,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,   // pooled_value
    output logic                                 m_tlast
);

    localparam int TW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int AW = $clog2(MAX_WIDTH);

    logic                   accept, stage_ready, ram_we, ram_re, avg_mode;
    logic [AW-1:0]          ram_addr;
    logic [SAMPLE_BITS-1:0] upper, out_value;
    pool22_pkg::item_tag_t  tag;

    assign pready   = 1'b1;
    assign s_tready = stage_ready;

    pool22_seq #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .s_valid    (s_tvalid),
        .stage_ready(stage_ready),
        .accept     (accept),
        .tag        (tag),
        .ram_we     (ram_we),
        .ram_re     (ram_re),
        .ram_addr   (ram_addr),
        .avg_mode   (avg_mode)
    );

    pool22_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_line (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_addr),
        .wdata(s_tdata[SAMPLE_BITS-1:0]),
        .re   (ram_re),
        .raddr(ram_addr),
        .rdata(upper)
    );

    pool22_calc #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_calc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .tag        (tag),
        .sample     (s_tdata[SAMPLE_BITS-1:0]),
        .upper      (upper),
        .avg_mode   (avg_mode),
        .stage_ready(stage_ready),
        .out_valid  (m_tvalid),
        .out_value  (out_value),
        .out_last   (m_tlast),
        .out_ready  (m_tready)
    );

    assign m_tdata = TW'(out_value);

endmodule

// ===== sv/pool22_chk.sv =====
`timescale 1ns / 1ps

module pool22_chk #(
    parameter int TW = 16
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [TW-1:0] m_tdata,
    input logic          m_tlast
);

    // a waiting result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // reset leaves no result pending
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a new result appears only after an item was taken
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching input item");

    // a result that waits blocks the input only when the window stage is full too
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with result side empty");

endmodule

bind pool_2x2_stride2_stream pool22_chk #(
    .TW(((SAMPLE_BITS + 7) / 8) * 8)
) u_pool22_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

// ===== test/pool22_checker.sv =====
`timescale 1ns / 1ps

module pool22_checker
    import pool22_pkg::*;
#(
    parameter int MAX_COLS = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    input  logic                     pready,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [15:0]              s_tdata,   // sample
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [15:0]              m_tdata,   // pooled_value
    input  logic                     m_tlast,
    output int                       fail_count,
    output int                       pending,
    output int                       checked,
    output int                       planes_done
);

    typedef struct packed {
        logic signed [15:0] value;
        logic               last;
    } pooled_t;

    pooled_t            expected_pool[$];
    pooled_t            oldest;

    logic signed [15:0] line_store [MAX_COLS];
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic                   avg_mode;
    logic [9:0]             col_count;
    logic [ROW_BITS-1:0]    row_count;
    logic signed [15:0]     held_left;
    logic signed [15:0]     held_upper_left;

    function automatic logic signed [15:0] larger(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
        return (a > b) ? a : b;
    endfunction

    // window prediction for one accepted item
    task automatic pool_step(input logic signed [15:0] x);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        int unsigned        r;
        row_kind_t          kind;
        logic signed [17:0] sum;
        logic signed [15:0] top;
        logic signed [15:0] value;
        logic               emit;
        logic               frame_end;
        if (width_reg == 0) w = 1;
        else if (width_reg > MAX_COLS) w = MAX_COLS;
        else w = 32'(width_reg);
        if (height_reg == 0) h = 1;
        else if (height_reg > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        else h = 32'(height_reg);
        c = 32'(col_count);
        r = 32'(row_count);
        if (c >= w) c = 0;
        if (r >= h) r = 0;
        if (r[0]) kind = KIND_FULL;
        else if (h[0] && r == h - 1) kind = KIND_PAD;
        else kind = KIND_STORE;
        emit  = 1'b0;
        value = '0;
        case (kind)
            KIND_STORE: begin
                line_store[c] = x;
            end
            // lower row missing: -inf for max, zero for average (still /4)
            KIND_PAD: begin
                if (c[0]) begin
                    sum   = 18'(held_left) + 18'(x);
                    value = avg_mode ? 16'(sum >>> 2) : larger(held_left, x);
                    emit  = 1'b1;
                end else if (c == w - 1) begin
                    value = avg_mode ? x >>> 1 : x;
                    emit  = 1'b1;
                end else begin
                    held_left = x;
                end
            end
            default: begin
                top = line_store[c];
                if (c[0]) begin
                    sum   = 18'(held_upper_left) + 18'(top) + 18'(held_left) + 18'(x);
                    value = avg_mode ? 16'(sum >>> 2)
                                     : larger(larger(held_upper_left, top), larger(held_left, x));
                    emit  = 1'b1;
                end else if (c == w - 1) begin
                    // odd last column: vertical pair only
                    sum   = 18'(top) + 18'(x);
                    value = avg_mode ? 16'(sum >>> 1) : larger(top, x);
                    emit  = 1'b1;
                end else begin
                    held_left       = x;
                    held_upper_left = top;
                end
            end
        endcase
        frame_end = 1'b0;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) begin
                r = 0;
                frame_end = 1'b1;
            end
        end
        col_count = c[9:0];
        row_count = r[ROW_BITS-1:0];
        if (emit) expected_pool.push_back('{value: value, last: frame_end});
    endtask

    initial begin
        for (int i = 0; i < MAX_COLS; i++) line_store[i] = '0;
        fail_count  = 0;
        pending     = 0;
        checked     = 0;
        planes_done = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_pool.delete();
            width_reg       = WIDTH_BITS'(2);
            height_reg      = HEIGHT_BITS'(2);
            avg_mode        = 1'b0;
            col_count       = '0;
            row_count       = '0;
            held_left       = '0;
            held_upper_left = '0;
        end else begin
            // a result leaves well after its item, so compare before predicting
            if (m_tvalid && m_tready) begin
                if (expected_pool.size() == 0) begin
                    $error("pooled_value: nothing expected, got %0d", $signed(m_tdata));
                    fail_count++;
                end else begin
                    oldest = expected_pool.pop_front();
                    if (m_tdata !== oldest.value) begin
                        $error("pooled_value: expected %0d, got %0d",
                               oldest.value, $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tlast !== oldest.last) begin
                        $error("frame_last: expected %0d, got %0d", oldest.last, m_tlast);
                        fail_count++;
                    end
                    checked++;
                    if (oldest.last) planes_done++;
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_WIDTH:  width_reg  = pwdata[WIDTH_BITS-1:0];
                    REG_HEIGHT: height_reg = pwdata[HEIGHT_BITS-1:0];
                    REG_MODE:   avg_mode   = pwdata[0];
                    default: ;
                endcase
                // any write restarts the plane
                col_count = '0;
                row_count = '0;
            end
            if (s_tvalid && s_tready) pool_step(s_tdata);
        end
        pending = expected_pool.size();
    end

endmodule

// ===== test/tb_pool_2x2_stride2_stream.sv =====
`timescale 1ns / 1ps

module tb_pool_2x2_stride2_stream;

    import pool22_pkg::*;

    localparam int       MAX_GAP      = 18;
    localparam int       HOLD_CYCLES  = 200;
    localparam int       STALL_LIMIT  = 2000;
    localparam int       PIPE_SETTLE  = 4;
    localparam int       RANDOM_ITEMS = 320;
    localparam reg_idx_t REG_SPARE    = 2'd3;

    logic                     aclk;
    logic                     aresetn;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [15:0]              s_tdata;   // sample
    logic                     m_tvalid;
    logic                     m_tready;
    logic [15:0]              m_tdata;   // pooled_value
    logic                     m_tlast;

    int   fail_count;
    int   pending;
    int   checked;
    int   planes_done;
    int   items_sent;
    int   stall_cycles;
    logic send_quiet;
    logic recv_quiet;
    logic hold_req;

    pool_2x2_stride2_stream i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    pool22_checker i_pool_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked),
        .planes_done (planes_done)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_cycles <= 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("pool_2x2_stride2_stream verification failed");
                $finish;
            end
        end
    end

    // result side: random back-pressure, plus a long hold-off on request
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_sample(input logic [15:0] value);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    // let every result out, then let an item still in the pipe settle
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (PIPE_SETTLE) @(negedge aclk);
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_plane(input int w, input int h, input logic avg);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_MODE, CFG_DATA_BITS'(avg));
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int w;
        int h;
        int n;
        int planes;
        int random_sent;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        aresetn    = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // reset setting: 2x2 plane, max
        send_sample(16'h8000); send_sample(16'h7fff);
        send_sample(16'hffff); send_sample(16'h0000);
        drain_results();

        // odd width and height, average: odd column pair, padded row, corner
        set_plane(3, 3, 1'b1);
        send_sample(16'h8000); send_sample(16'h8000); send_sample(16'h7fff);
        send_sample(16'h8000); send_sample(16'h8000); send_sample(16'hffff);
        send_sample(16'h7fff); send_sample(16'h0001); send_sample(16'h8001);
        drain_results();
        cfg_write(REG_MODE, CFG_DATA_BITS'(1'b0));
        send_sample(16'h7fff); send_sample(16'h8000); send_sample(16'h8001);
        send_sample(16'h8000); send_sample(16'h8000); send_sample(16'h8000);
        send_sample(16'h8000); send_sample(16'h7fff); send_sample(16'hffff);
        drain_results();

        // zero width and height act as one
        set_plane(0, 0, 1'b0);
        send_sample(16'h8000); send_sample(16'h7fff); send_sample(16'hffff);
        drain_results();
        cfg_write(REG_MODE, CFG_DATA_BITS'(1'b1));
        send_sample(16'h8001); send_sample(16'h7fff); send_sample(16'hffff);
        drain_results();

        // unused index restarts the plane; tall plane left unfinished
        cfg_write(REG_SPARE, 32'hffff_ffff);
        set_plane(2, 8191, 1'b0);
        repeat (6) send_sample(pick_sample());
        drain_results();

        // oversized width clips to the line store size; long receiver hold-off
        set_plane(1500, 1, 1'b1);
        send_quiet = 1'b1;
        hold_req   = 1'b1;
        repeat (1026) send_sample(pick_sample());
        send_quiet = 1'b0;
        drain_results();

        w = 2;
        h = 2;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            drain_results();
            if ($urandom_range(0, 3) != 0) begin
                n = $urandom_range(0, 19);
                if (n < 14) w = $urandom_range(1, 8);
                else if (n < 19) w = $urandom_range(9, 40);
                else w = $urandom_range(1, 2);
                h = (w > 8) ? $urandom_range(1, 4) : $urandom_range(1, 9);
                cfg_write(REG_WIDTH, w);
                cfg_write(REG_HEIGHT, h);
            end
            if ($urandom_range(0, 1) != 0) cfg_write(REG_MODE, $urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) cfg_write(REG_SPARE, $urandom);
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) begin
                send_quiet = 1'b1;
                hold_req   = 1'b1;
            end
            planes = $urandom_range(1, 3);
            for (int p = 0; p < planes; p++) begin
                n = w * h;
                // now and then a plane is cut short
                if (p == planes - 1 && $urandom_range(0, 6) == 0) n = $urandom_range(1, n);
                repeat (n) send_sample(pick_sample());
                random_sent += n;
            end
        end
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        drain_results();
        repeat (8) @(negedge aclk);

        $display("sent %0d samples; checked %0d pooled values over %0d finished planes",
                 items_sent, checked, planes_done);
        $display("max and average modes, odd rows and columns, widths 1..1024 with clipping");
        if (fail_count == 0) begin
            $display("pool_2x2_stride2_stream verification clean");
        end else begin
            $display("pool_2x2_stride2_stream verification failed");
        end
        $finish;
    end

endmodule
